// ===== rtl/grouped_conv2d_point_unit_macros.svh =====
// Assertion macros shared by the grouped convolution point unit.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef GROUPED_CONV2D_POINT_UNIT_MACROS_SVH
`define GROUPED_CONV2D_POINT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define GCP_ASSERT_NOW(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error("assertion failed");
`define GCP_ASSERT_NEXT(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error("assertion failed");
`else
`define GCP_ASSERT_NOW(lbl, pre, con)
`define GCP_ASSERT_NEXT(lbl, pre, con)
`endif
`endif

// ===== rtl/gcp_pkg.sv =====
// Shared types, codes and constants of the grouped convolution point unit.
// No dependencies; the sigmoid table builder runs at elaboration only.
package gcp_pkg;

    localparam int FRAC_BITS = 8;
    localparam int SIG_SHIFT = FRAC_BITS - 4;
    localparam int ACC_W     = 48;

    typedef enum logic [1:0] {
        KIND_WEIGHT  = 2'd0,
        KIND_BIAS    = 2'd1,
        KIND_ACT     = 2'd2,
        KIND_COMPUTE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_KERNEL_SIZE   = 3'd0,
        CFG_STRIDE_STEP   = 3'd1,
        CFG_PAD_AMOUNT    = 3'd2,
        CFG_IN_HEIGHT     = 3'd3,
        CFG_IN_WIDTH      = 3'd4,
        CFG_IN_PER_GROUP  = 3'd5,
        CFG_OUT_PER_GROUP = 3'd6,
        CFG_SILU_ENABLE   = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_RUN,
        ST_DRAIN,
        ST_POST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic init;   // load accumulator with the bias
        logic issue;  // a tap read went out this cycle
    } mac_ctrl_t;

    typedef logic [7:0] sig_table_t [256];

    localparam logic [63:0] Q30_ONE      = 64'd1073741824;
    localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687096;

    // round(256 * sigmoid((i - 128) / 16)), powers of exp(-1/16) in Q30
    function automatic sig_table_t build_sig_table();
        logic [63:0] pw [129];
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] n2;
        logic [63:0] d2;
        logic [63:0] rem;
        logic [63:0] quo;
        sig_table_t  tbl;
        int          d;
        int          ad;
        pw[0] = Q30_ONE;
        for (int i = 1; i <= 128; i++) begin
            pw[i] = (pw[i - 1] * EXP_STEP_Q30 + (Q30_ONE >> 1)) >> 30;
        end
        for (int i = 0; i < 256; i++) begin
            d   = i - 128;
            ad  = (d < 0) ? -d : d;
            e   = pw[ad];
            num = (d >= 0) ? Q30_ONE : e;
            den = Q30_ONE + e;
            n2  = num * 64'd512 + den;
            d2  = den << 1;
            rem = '0;
            quo = '0;
            // long division, one quotient bit per step
            for (int b = 63; b >= 0; b--) begin
                rem = {rem[62:0], n2[b]};
                if (rem >= d2) begin
                    rem    = rem - d2;
                    quo[b] = 1'b1;
                end
            end
            tbl[i] = (quo > 64'd255) ? 8'hFF : quo[7:0];
        end
        return tbl;
    endfunction

endpackage

// ===== rtl/gcp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the weight, bias and activation stores.
module gcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gcp_mac.sv =====
// Multiply-accumulate pipeline: product stage, then accumulate.
// Depends on gcp_pkg for the control struct and accumulator width.
module gcp_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gcp_pkg::mac_ctrl_t                ctrl,
    input  logic signed [15:0]                bias,
    input  logic signed [15:0]                act_data,
    input  logic signed [15:0]                wt_data,
    output logic signed [gcp_pkg::ACC_W-1:0]  acc,
    output logic                              busy
);
    import gcp_pkg::*;

    logic                    p1_reg;
    logic                    p2_reg;
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= ctrl.issue;
            p2_reg <= p1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(act_data) * 32'(wt_data);
        if (ctrl.init)
        begin
            acc_reg <= ACC_W'(bias) <<< FRAC_BITS;
        end
        else if (p2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc  = acc_reg;
    assign busy = p1_reg | p2_reg;

endmodule

// ===== rtl/gcp_act.sv =====
// Output stage: round and saturate to Q8.8, then optional SiLU by table.
// Depends on gcp_pkg for widths and the sigmoid table builder.
module gcp_act (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [gcp_pkg::ACC_W-1:0]  acc,
    input  logic                              silu_en,
    output logic                              valid,
    output logic signed [15:0]                value
);
    import gcp_pkg::*;

    localparam sig_table_t SIG_TABLE = build_sig_table();
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(32768));

    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] rnd_shift;
    logic signed [15:0]      sat_val;
    logic signed [15:0]      idx_full;
    logic [7:0]              idx8;
    logic [7:0]              entry;
    logic signed [24:0]      prod_full;
    logic signed [24:0]      silu_sum;

    logic                    va_reg;
    logic                    vb_reg;
    logic                    vo_reg;
    logic                    silu_a_reg;
    logic                    silu_b_reg;
    logic signed [15:0]      r_reg;
    logic signed [15:0]      rb_reg;
    logic signed [24:0]      pb_reg;
    logic signed [15:0]      value_reg;

    always_comb
    begin
        rnd_sum   = acc + HALF;
        rnd_shift = rnd_sum >>> FRAC_BITS;
        if (rnd_shift > SAT_HI)
        begin
            sat_val = 16'sh7FFF;
        end
        else if (rnd_shift < SAT_LO)
        begin
            sat_val = 16'sh8000;
        end
        else
        begin
            sat_val = rnd_shift[15:0];
        end
    end

    always_comb
    begin
        idx_full = r_reg >>> SIG_SHIFT;
        if (idx_full > 16'sd127)
        begin
            idx8 = 8'hFF;
        end
        else if (idx_full < -16'sd128)
        begin
            idx8 = 8'h00;
        end
        else
        begin
            idx8 = idx_full[7:0] ^ 8'h80;
        end
        entry     = SIG_TABLE[idx8];
        prod_full = 25'(r_reg) * 25'($signed({1'b0, entry}));
        silu_sum  = pb_reg + 25'sd128;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            va_reg <= start;
            vb_reg <= va_reg;
            vo_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= sat_val;
        silu_a_reg <= silu_en;
        rb_reg     <= r_reg;
        pb_reg     <= prod_full;
        silu_b_reg <= silu_a_reg;
        value_reg  <= silu_b_reg ? silu_sum[23:8] : rb_reg;
    end

    assign valid = vo_reg;
    assign value = value_reg;

endmodule

// ===== rtl/grouped_conv2d_point_unit.sv =====
// Grouped 2-D convolution point unit, Q8.8, bias and optional SiLU.
// A write is stored at its accepting edge; a compute item walks its taps with at most
// one MAC per cycle (bound by the single read port of each store), then drains; a point
// that fails the range check goes from the check state, and a tap off a store from run, to done.
// done is high for one cycle and start is taken again the cycle after; busy holds
// off start meanwhile. Async reset restores register defaults; stores stay undefined.
module grouped_conv2d_point_unit #(
    parameter int WEIGHT_DEPTH = 16384,
    parameter int ACT_DEPTH    = 16384,
    parameter int MAX_CHANNELS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    // command
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         kind,
    input  logic [13:0]        address,
    input  logic signed [15:0] data_value,
    input  logic [7:0]         out_channel,
    input  logic [6:0]         out_row,
    input  logic [6:0]         out_col,
    // result
    output logic               done,
    output logic signed [15:0] result_value,
    output logic               error_flag
);
    import gcp_pkg::*;

    `include "grouped_conv2d_point_unit_macros.svh"

    localparam int WAW  = $clog2(WEIGHT_DEPTH);
    localparam int AAW  = $clog2(ACT_DEPTH);
    localparam int BAW  = $clog2(MAX_CHANNELS);
    localparam int WI_W = 24;   // weight index: oc*cpg*K*K + taps
    localparam int AI_W = 36;   // activation index, signed while in padding

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [2:0] kernel_size_reg;
    logic [2:0] stride_step_reg;
    logic [1:0] pad_amount_reg;
    logic [7:0] in_height_reg;
    logic [7:0] in_width_reg;
    logic [8:0] in_per_group_reg;
    logic [8:0] out_per_group_reg;
    logic       silu_enable_reg;

    state_t state_reg;
    state_t state_next;

    // command / point
    logic [7:0] oc_reg;
    logic [6:0] oy_reg;
    logic [6:0] ox_reg;
    logic       err_reg;
    logic signed [15:0] result_reg;

    // group divider (oc / out_per_group), one quotient bit per cycle
    logic [7:0] dvd_reg;
    logic [8:0] rem_reg;
    logic [7:0] quo_reg;
    logic [2:0] cnt_reg;

    // setup products
    logic [16:0]           prod1_reg;
    logic [16:0]           gc_reg;
    logic [15:0]           hw_reg;
    logic [5:0]            kk_reg;
    logic signed [11:0]    oys_reg;
    logic signed [11:0]    oxs_reg;
    logic signed [AI_W-1:0] abase_reg;
    logic signed [AI_W-1:0] oysw_reg;

    // tap walk
    logic [WI_W-1:0]        wi_reg;
    logic signed [AI_W-1:0] row0_reg;
    logic signed [AI_W-1:0] rowbase_reg;
    logic signed [11:0]     iy_reg;
    logic signed [11:0]     ix_reg;
    logic [8:0]             ic_reg;
    logic [2:0]             ky_reg;
    logic [2:0]             kx_reg;

    logic in_accept;
    logic [2:0]  s_eff;
    logic [9:0]  ys_mul;
    logic [9:0]  xs_mul;
    logic [9:0]  span_h;
    logic [9:0]  span_w;
    logic        point_ok;
    logic [9:0]  div_t;
    logic        div_ge;
    logic [7:0]  grp;
    logic [2:0]  k_last;
    logic        no_taps;
    logic        tap_valid;
    logic        tap_oor;
    logic        tap_last;
    logic signed [AI_W-1:0] ai;
    logic signed [AI_W-1:0] hw_s;
    logic signed [AI_W-1:0] w_s;

    mac_ctrl_t              mac_ctrl;
    logic                   mac_busy;
    logic signed [ACC_W-1:0] acc;
    logic                   act_start;
    logic                   act_valid;
    logic signed [15:0]     act_value;

    logic [15:0] wt_rdata;
    logic [15:0] act_rdata;
    logic [15:0] bias_rdata;

    assign in_accept = start && !busy;

    // ------------------------------------------------------------------
    // stores: one write per accepted in-range load transfer, reads during compute
    // ------------------------------------------------------------------
    gcp_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_wt_ram (
        .clk   (clk),
        .we    (in_accept && kind == KIND_WEIGHT && 32'(address) < WEIGHT_DEPTH),
        .waddr (WAW'(address)),
        .wdata (data_value),
        .raddr (wi_reg[WAW-1:0]),
        .rdata (wt_rdata)
    );

    gcp_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
        .clk   (clk),
        .we    (in_accept && kind == KIND_ACT && 32'(address) < ACT_DEPTH),
        .waddr (AAW'(address)),
        .wdata (data_value),
        .raddr (ai[AAW-1:0]),
        .rdata (act_rdata)
    );

    // bias read address sits on the latched channel for the whole item
    gcp_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_bias_ram (
        .clk   (clk),
        .we    (in_accept && kind == KIND_BIAS && 32'(address) < MAX_CHANNELS),
        .waddr (BAW'(address)),
        .wdata (data_value),
        .raddr (BAW'(oc_reg)),
        .rdata (bias_rdata)
    );

    // ------------------------------------------------------------------
    // point check: oy < out_size  <=>  oy*s + K <= n + 2*pad
    // ------------------------------------------------------------------
    always_comb
    begin
        s_eff    = (stride_step_reg == 3'd0) ? 3'd1 : stride_step_reg;
        ys_mul   = 10'(oy_reg) * 10'(s_eff);
        xs_mul   = 10'(ox_reg) * 10'(s_eff);
        span_h   = 10'(in_height_reg) + 10'({pad_amount_reg, 1'b0});
        span_w   = 10'(in_width_reg) + 10'({pad_amount_reg, 1'b0});
        point_ok = (ys_mul + 10'(kernel_size_reg) <= span_h)
                && (xs_mul + 10'(kernel_size_reg) <= span_w)
                && (32'(oc_reg) < MAX_CHANNELS);
    end

    // restoring divider step
    always_comb
    begin
        div_t  = {rem_reg, dvd_reg[7]};
        div_ge = div_t >= 10'(out_per_group_reg);
        grp    = (out_per_group_reg == 9'd0) ? 8'd0 : quo_reg;
    end

    // ------------------------------------------------------------------
    // current tap: padding test, store bounds, last tap
    // ------------------------------------------------------------------
    always_comb
    begin
        k_last    = kernel_size_reg - 3'd1;
        no_taps   = (in_per_group_reg == 9'd0) || (kernel_size_reg == 3'd0);
        hw_s      = $signed(AI_W'(hw_reg));
        w_s       = $signed(AI_W'(in_width_reg));
        ai        = rowbase_reg + AI_W'(ix_reg);
        tap_valid = (iy_reg >= 12'sd0) && (iy_reg < $signed(12'(in_height_reg)))
                 && (ix_reg >= 12'sd0) && (ix_reg < $signed(12'(in_width_reg)));
        tap_oor   = tap_valid && ((wi_reg >= WI_W'(WEIGHT_DEPTH))
                               || (ai >= $signed(AI_W'(ACT_DEPTH))));
        tap_last  = (ic_reg == in_per_group_reg - 9'd1)
                 && (ky_reg == k_last) && (kx_reg == k_last);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && kind == KIND_COMPUTE)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:  state_next = point_ok ? ST_DIV : ST_DONE;
            ST_DIV:    state_next = (cnt_reg == 3'd7) ? ST_MUL1 : ST_DIV;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = no_taps ? ST_DRAIN : ST_RUN;
            ST_RUN:
            begin
                if (tap_oor)
                begin
                    state_next = ST_DONE;
                end
                else if (tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = mac_busy ? ST_DRAIN : ST_POST;
            ST_POST:   state_next = act_valid ? ST_DONE : ST_POST;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy           = state_reg != ST_IDLE;
        done           = state_reg == ST_DONE;
        mac_ctrl.init  = state_reg == ST_MUL1;
        mac_ctrl.issue = (state_reg == ST_RUN) && tap_valid && !tap_oor;
        act_start      = (state_reg == ST_DRAIN) && !mac_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            kernel_size_reg   <= 3'd3;
            stride_step_reg   <= 3'd1;
            pad_amount_reg    <= 2'd1;
            in_height_reg     <= 8'd1;
            in_width_reg      <= 8'd1;
            in_per_group_reg  <= 9'd1;
            out_per_group_reg <= 9'd1;
            silu_enable_reg   <= 1'b0;
            err_reg           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_KERNEL_SIZE:   kernel_size_reg   <= cfg_data[2:0];
                    CFG_STRIDE_STEP:   stride_step_reg   <= cfg_data[2:0];
                    CFG_PAD_AMOUNT:    pad_amount_reg    <= cfg_data[1:0];
                    CFG_IN_HEIGHT:     in_height_reg     <= cfg_data[7:0];
                    CFG_IN_WIDTH:      in_width_reg      <= cfg_data[7:0];
                    CFG_IN_PER_GROUP:  in_per_group_reg  <= cfg_data;
                    CFG_OUT_PER_GROUP: out_per_group_reg <= cfg_data;
                    CFG_SILU_ENABLE:   silu_enable_reg   <= cfg_data[0];
                endcase
            end
            if (state_reg == ST_IDLE && in_accept)
            begin
                err_reg <= 1'b0;
            end
            else if ((state_reg == ST_CHECK && !point_ok)
                  || (state_reg == ST_RUN && tap_oor))
            begin
                err_reg <= 1'b1;
            end
        end
    end

    // datapath registers (no reset needed)
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    oc_reg <= out_channel;
                    oy_reg <= out_row;
                    ox_reg <= out_col;
                end
            end
            ST_CHECK:
            begin
                dvd_reg    <= oc_reg;
                rem_reg    <= '0;
                quo_reg    <= '0;
                cnt_reg    <= '0;
                result_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? 9'(div_t - 10'(out_per_group_reg)) : div_t[8:0];
                quo_reg <= {quo_reg[6:0], div_ge};
                dvd_reg <= {dvd_reg[6:0], 1'b0};
                cnt_reg <= cnt_reg + 3'd1;
            end
            ST_MUL1:
            begin
                prod1_reg <= 17'(oc_reg) * 17'(in_per_group_reg);
                gc_reg    <= 17'(grp) * 17'(in_per_group_reg);
                hw_reg    <= 16'(in_height_reg) * 16'(in_width_reg);
                kk_reg    <= 6'(kernel_size_reg) * 6'(kernel_size_reg);
                oys_reg   <= $signed(12'(ys_mul)) - $signed(12'(pad_amount_reg));
                oxs_reg   <= $signed(12'(xs_mul)) - $signed(12'(pad_amount_reg));
            end
            ST_MUL2:
            begin
                wi_reg    <= WI_W'(prod1_reg) * WI_W'(kk_reg);
                abase_reg <= $signed(AI_W'(gc_reg) * AI_W'(hw_reg));
                oysw_reg  <= AI_W'(oys_reg) * w_s;
            end
            ST_MUL3:
            begin
                row0_reg    <= abase_reg + oysw_reg;
                rowbase_reg <= abase_reg + oysw_reg;
                iy_reg      <= oys_reg;
                ix_reg      <= oxs_reg;
                ic_reg      <= '0;
                ky_reg      <= '0;
                kx_reg      <= '0;
            end
            ST_RUN:
            begin
                // weight index runs linearly, skipped taps included
                wi_reg <= wi_reg + WI_W'(1);
                if (tap_oor)
                begin
                    result_reg <= '0;
                end
                if (kx_reg == k_last)
                begin
                    kx_reg <= '0;
                    ix_reg <= oxs_reg;
                    if (ky_reg == k_last)
                    begin
                        ky_reg      <= '0;
                        iy_reg      <= oys_reg;
                        ic_reg      <= ic_reg + 9'd1;
                        row0_reg    <= row0_reg + hw_s;
                        rowbase_reg <= row0_reg + hw_s;
                    end
                    else
                    begin
                        ky_reg      <= ky_reg + 3'd1;
                        iy_reg      <= iy_reg + 12'sd1;
                        rowbase_reg <= rowbase_reg + w_s;
                    end
                end
                else
                begin
                    kx_reg <= kx_reg + 3'd1;
                    ix_reg <= ix_reg + 12'sd1;
                end
            end
            ST_POST:
            begin
                if (act_valid)
                begin
                    result_reg <= act_value;
                end
            end
            default:
            begin
            end
        endcase
    end

    gcp_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .bias     ($signed(bias_rdata)),
        .act_data ($signed(act_rdata)),
        .wt_data  ($signed(wt_rdata)),
        .acc      (acc),
        .busy     (mac_busy)
    );

    gcp_act u_act (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (act_start),
        .acc     (acc),
        .silu_en (silu_enable_reg),
        .valid   (act_valid),
        .value   (act_value)
    );

    assign result_value = result_reg;
    assign error_flag   = err_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `GCP_ASSERT_NEXT(a_done_then_idle, done, !busy)
    `GCP_ASSERT_NEXT(a_compute_goes_busy, in_accept && kind == KIND_COMPUTE, busy)
    `GCP_ASSERT_NEXT(a_load_no_result, in_accept && kind != KIND_COMPUTE, !done)
    `GCP_ASSERT_NOW(a_error_zero, done && error_flag, result_value == 16'sd0)

endmodule

// ===== tb/grouped_conv2d_point_checker.sv =====
// Checker for the grouped convolution point unit: watches config writes,
// command transfers and result strobes, predicts each result and compares.
// Depends on gcp_pkg for the kind and register index codes.
`timescale 1ns / 1ps

module grouped_conv2d_point_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         kind,
    input  logic [13:0]        address,
    input  logic signed [15:0] data_value,
    input  logic [7:0]         out_channel,
    input  logic [6:0]         out_row,
    input  logic [6:0]         out_col,
    input  logic               done,
    input  logic signed [15:0] result_value,
    input  logic               error_flag,
    output int                 fail_count,
    output int                 pending
);
    import gcp_pkg::*;

    localparam int WSIZE = 16384;
    localparam int ASIZE = 16384;
    localparam int BSIZE = 256;

    typedef struct packed {
        logic signed [15:0] value;
        logic               err;
    } point_result_t;

    logic signed [15:0] weights [WSIZE];
    logic signed [15:0] acts    [ASIZE];
    logic signed [15:0] biases  [BSIZE];
    int unsigned        sigmoid_q8 [256];
    point_result_t      expected_q [$];

    logic [2:0] ksize;
    logic [2:0] stride;
    logic [1:0] pad;
    logic [7:0] height;
    logic [7:0] width;
    logic [8:0] ch_per_grp;
    logic [8:0] oc_per_grp;
    logic       silu_on;

    // Q0.8 logistic table from successive Q30 powers of exp(-1/16)
    function automatic void fill_sigmoid();
        longint unsigned pw [129];
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned s;
        int              d;
        pw[0] = 64'd1073741824;
        for (int i = 1; i <= 128; i++)
            pw[i] = (pw[i - 1] * 64'd1008687096 + 64'd536870912) >> 30;
        for (int i = 0; i < 256; i++)
        begin
            d   = i - 128;
            e   = pw[(d < 0) ? -d : d];
            num = (d >= 0) ? 64'd1073741824 : e;
            den = 64'd1073741824 + e;
            s   = (num * 512 + den) / (2 * den);
            sigmoid_q8[i] = (s > 255) ? 255 : int'(s);
        end
    endfunction

    function automatic longint unsigned axis_points(longint unsigned n, longint unsigned k,
                                                    longint unsigned p, longint unsigned s);
        longint unsigned span;
        span = n + 2 * p;
        if (span < k)
            return 0;
        return (span - k) / s + 1;
    endfunction

    function automatic point_result_t conv_point(longint unsigned oc, longint unsigned oy,
                                                 longint unsigned ox);
        point_result_t   res;
        longint unsigned k;
        longint unsigned s;
        longint unsigned cpg;
        longint unsigned grp;
        longint unsigned ch;
        longint unsigned wi;
        longint unsigned ai;
        longint          iy;
        longint          ix;
        longint          acc;
        longint          r;
        longint          idx;
        res.value = '0;
        res.err   = 1'b1;
        k   = ksize;
        s   = (stride == 0) ? 1 : stride;
        cpg = ch_per_grp;
        grp = (oc_per_grp == 0) ? 0 : oc / oc_per_grp;
        if (oy >= axis_points(height, k, pad, s) || ox >= axis_points(width, k, pad, s)
            || oc >= BSIZE)
            return res;
        acc = longint'(biases[oc]) * 256;
        for (longint unsigned ic = 0; ic < cpg; ic++)
        begin
            ch = grp * cpg + ic;
            for (longint unsigned ky = 0; ky < k; ky++)
            begin
                iy = longint'(oy * s + ky) - longint'(pad);
                if (iy < 0 || iy >= longint'(height))
                    continue;
                for (longint unsigned kx = 0; kx < k; kx++)
                begin
                    ix = longint'(ox * s + kx) - longint'(pad);
                    if (ix < 0 || ix >= longint'(width))
                        continue;
                    wi = ((oc * cpg + ic) * k + ky) * k + kx;
                    ai = (ch * height + longint'(iy)) * width + longint'(ix);
                    if (wi >= WSIZE || ai >= ASIZE)
                        return res;
                    acc += longint'(acts[ai]) * longint'(weights[wi]);
                end
            end
        end
        // round half up, then saturate to 16 bits
        r = (acc + 128) >>> 8;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        if (silu_on)
        begin
            idx = r >>> 4;
            if (idx < -128)
                idx = -128;
            if (idx > 127)
                idx = 127;
            r = (r * longint'(sigmoid_q8[idx + 128]) + 128) >>> 8;
        end
        res.value = r[15:0];
        res.err   = 1'b0;
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        fill_sigmoid();
    end

    always @(posedge clk or negedge rst_n)
    begin
        point_result_t want;
        if (!rst_n)
        begin
            ksize      <= 3'd3;
            stride     <= 3'd1;
            pad        <= 2'd1;
            height     <= 8'd1;
            width      <= 8'd1;
            ch_per_grp <= 9'd1;
            oc_per_grp <= 9'd1;
            silu_on    <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                    report("result with nothing outstanding", result_value, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (error_flag !== want.err)
                        report("error_flag", error_flag, want.err);
                    if (result_value !== want.value)
                        report("result_value", result_value, want.value);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_KERNEL_SIZE:   ksize      <= cfg_data[2:0];
                    CFG_STRIDE_STEP:   stride     <= cfg_data[2:0];
                    CFG_PAD_AMOUNT:    pad        <= cfg_data[1:0];
                    CFG_IN_HEIGHT:     height     <= cfg_data[7:0];
                    CFG_IN_WIDTH:      width      <= cfg_data[7:0];
                    CFG_IN_PER_GROUP:  ch_per_grp <= cfg_data;
                    CFG_OUT_PER_GROUP: oc_per_grp <= cfg_data;
                    CFG_SILU_ENABLE:   silu_on    <= cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (kind_t'(kind))
                    KIND_WEIGHT:  weights[address] = data_value;
                    KIND_BIAS:    if (address < BSIZE) biases[address] = data_value;
                    KIND_ACT:     acts[address] = data_value;
                    KIND_COMPUTE: expected_q.push_back(conv_point(out_channel, out_row,
                                                                  out_col));
                    default: ;
                endcase
            end
            pending = expected_q.size();
        end
    end

endmodule

// ===== tb/tb_grouped_conv2d_point_unit.sv =====
// Top of the grouped convolution point unit testbench: clock, reset, stimulus
// and verdict. Depends on gcp_pkg, the unit and grouped_conv2d_point_checker.
`timescale 1ns / 1ps

module tb_grouped_conv2d_point_unit;
    import gcp_pkg::*;

    localparam int IDLE_LIMIT  = 200000;  // cycles without a transfer, result or config write
    localparam int ITEM_TARGET = 1750;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [8:0]         cfg_data;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [13:0]        address;
    logic signed [15:0] data_value;
    logic [7:0]         out_channel;
    logic [6:0]         out_row;
    logic [6:0]         out_col;
    logic               done;
    logic signed [15:0] result_value;
    logic               error_flag;
    int                 fail_count;
    int                 pending;

    // Our own copy of the register file, used only to plan legal points and
    // to stage every operand a point reads before the point is requested.
    int unsigned k_cfg;
    int unsigned s_cfg;
    int unsigned p_cfg;
    int unsigned h_cfg;
    int unsigned w_cfg;
    int unsigned ipg_cfg;
    int unsigned opg_cfg;

    // Stores have no defined reset contents: track what has been loaded so a
    // compute never reads an entry that was never written.
    bit          weight_loaded [16384];
    bit          act_loaded    [16384];
    bit          bias_loaded   [256];
    int          sent_items;
    int          idle_cycles;
    bit          no_gaps;

    grouped_conv2d_point_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .address      (address),
        .data_value   (data_value),
        .out_channel  (out_channel),
        .out_row      (out_row),
        .out_col      (out_col),
        .done         (done),
        .result_value (result_value),
        .error_flag   (error_flag)
    );

    grouped_conv2d_point_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .address      (address),
        .data_value   (data_value),
        .out_channel  (out_channel),
        .out_row      (out_row),
        .out_col      (out_col),
        .done         (done),
        .result_value (result_value),
        .error_flag   (error_flag),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // Watchdog: any command transfer, result or config write counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("grouped_conv2d_point_unit regression: fail");
            $finish;
        end
    end

    function automatic int unsigned out_points(int unsigned n);
        int unsigned span;
        int unsigned s;
        span = n + 2 * p_cfg;
        s    = (s_cfg == 0) ? 1 : s_cfg;
        if (span < k_cfg)
            return 0;
        return (span - k_cfg) / s + 1;
    endfunction

    // No gap or a short one most of the time, some long; none at all in no-gap stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 40)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // One command transfer; start stays high into the next transfer when
    // no gap follows.
    task automatic send_cmd(input kind_t k, input logic [13:0] adr,
                            input logic [15:0] dv, input logic [7:0] oc,
                            input logic [6:0] row, input logic [6:0] col);
        int gap;
        start       <= 1'b1;
        kind        <= k;
        address     <= adr;
        data_value  <= dv;
        out_channel <= oc;
        out_row     <= row;
        out_col     <= col;
        do
            @(posedge clk);
        while (busy);
        case (k)
            KIND_WEIGHT: weight_loaded[adr] = 1'b1;
            KIND_BIAS:   if (adr < 256) bias_loaded[adr] = 1'b1;
            KIND_ACT:    act_loaded[adr] = 1'b1;
            default: ;
        endcase
        sent_items++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load(input kind_t k, input int unsigned adr, input logic [15:0] dv);
        send_cmd(k, adr[13:0], dv, 8'($urandom), 7'($urandom), 7'($urandom));
    endtask

    // Load every operand the point will read that is not yet defined, in the
    // unit's tap order, up to the first tap index that falls off a store.
    task automatic stage_operands(input int unsigned oc, input int unsigned oy,
                                  input int unsigned ox);
        int unsigned s;
        int unsigned grp;
        int unsigned wi;
        int unsigned ai;
        int          iy;
        int          ix;
        s   = (s_cfg == 0) ? 1 : s_cfg;
        grp = (opg_cfg == 0) ? 0 : oc / opg_cfg;
        if (oy >= out_points(h_cfg) || ox >= out_points(w_cfg) || oc >= 256)
            return;
        if (!bias_loaded[oc])
            load(KIND_BIAS, oc, 16'($urandom));
        for (int unsigned ic = 0; ic < ipg_cfg; ic++)
            for (int unsigned ky = 0; ky < k_cfg; ky++)
            begin
                iy = int'(oy * s + ky) - int'(p_cfg);
                if (iy < 0 || iy >= int'(h_cfg))
                    continue;
                for (int unsigned kx = 0; kx < k_cfg; kx++)
                begin
                    ix = int'(ox * s + kx) - int'(p_cfg);
                    if (ix < 0 || ix >= int'(w_cfg))
                        continue;
                    wi = ((oc * ipg_cfg + ic) * k_cfg + ky) * k_cfg + kx;
                    ai = ((grp * ipg_cfg + ic) * h_cfg + iy) * w_cfg + ix;
                    if (wi >= 16384 || ai >= 16384)
                        return;
                    if (!weight_loaded[wi])
                        load(KIND_WEIGHT, wi, 16'($urandom));
                    if (!act_loaded[ai])
                        load(KIND_ACT, ai, 16'($urandom));
                end
            end
    endtask

    task automatic compute(input int unsigned oc, input int unsigned oy,
                           input int unsigned ox);
        stage_operands(oc, oy, ox);
        send_cmd(KIND_COMPUTE, 14'($urandom), 16'($urandom), oc[7:0], oy[6:0], ox[6:0]);
    endtask

    // Sender holds off until every result is back and the unit has settled;
    // a trailing write produces no strobe, so allow its latency as well.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[8:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_KERNEL_SIZE:   k_cfg   = val & 7;
            CFG_STRIDE_STEP:   s_cfg   = val & 7;
            CFG_PAD_AMOUNT:    p_cfg   = val & 3;
            CFG_IN_HEIGHT:     h_cfg   = val & 8'hFF;
            CFG_IN_WIDTH:      w_cfg   = val & 8'hFF;
            CFG_IN_PER_GROUP:  ipg_cfg = val & 9'h1FF;
            CFG_OUT_PER_GROUP: opg_cfg = val & 9'h1FF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_all(input int unsigned k, input int unsigned s, input int unsigned p,
                           input int unsigned h, input int unsigned w, input int unsigned ipg,
                           input int unsigned opg, input int unsigned silu);
        drain();
        write_reg(CFG_KERNEL_SIZE, k);
        write_reg(CFG_STRIDE_STEP, s);
        write_reg(CFG_PAD_AMOUNT, p);
        write_reg(CFG_IN_HEIGHT, h);
        write_reg(CFG_IN_WIDTH, w);
        write_reg(CFG_IN_PER_GROUP, ipg);
        write_reg(CFG_OUT_PER_GROUP, opg);
        write_reg(CFG_SILU_ENABLE, silu);
    endtask

    // A legal point most of the time, otherwise anywhere in the field ranges.
    task automatic random_point();
        int unsigned oh;
        int unsigned ow;
        oh = out_points(h_cfg);
        ow = out_points(w_cfg);
        if (oh > 0 && ow > 0 && $urandom_range(0, 9) < 8)
            compute($urandom_range(0, (opg_cfg > 0 && opg_cfg < 32) ? 4 * opg_cfg - 1 : 255),
                    $urandom_range(0, (oh > 128 ? 128 : oh) - 1),
                    $urandom_range(0, (ow > 128 ? 128 : ow) - 1));
        else
            compute($urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    // Stops early once the item budget is spent, staging loads included.
    task automatic run_phase(input int n);
        int roll;
        no_gaps = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (sent_items >= ITEM_TARGET)
                break;
            roll = $urandom_range(0, 99);
            if (roll < 72)
                random_point();
            else
                load(kind_t'($urandom_range(0, 2)), $urandom_range(0, 16383),
                     16'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        start       = 1'b0;
        kind        = KIND_WEIGHT;
        address     = '0;
        data_value  = '0;
        out_channel = '0;
        out_row     = '0;
        out_col     = '0;
        sent_items  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        // mirror of the reset defaults
        k_cfg = 3; s_cfg = 1; p_cfg = 1; h_cfg = 1; w_cfg = 1; ipg_cfg = 1; opg_cfg = 1;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, on reset settings: a 1x1 map padded to a single output point
        load(KIND_WEIGHT, 16383, 16'h8000);
        load(KIND_ACT, 16383, 16'h7FFF);
        load(KIND_BIAS, 300, 16'h1234);            // off the bias store, dropped
        load(KIND_BIAS, 0, 16'h7FFF);
        load(KIND_ACT, 0, 16'h7FFF);
        load(KIND_WEIGHT, 4, 16'h7FFF);
        compute(0, 0, 0);                           // saturates high
        load(KIND_WEIGHT, 4, 16'h8000);
        compute(0, 0, 0);                           // large negative product
        load(KIND_BIAS, 0, 16'h8000);
        load(KIND_ACT, 0, 16'h7FFF);
        compute(0, 0, 0);                           // saturates low
        compute(255, 0, 0);                         // top channel, own group
        compute(0, 127, 127);                       // outside the output size
        compute(0, 1, 0);

        // SiLU with biases near zero and beyond both table clamps
        set_all(1, 1, 0, 2, 2, 1, 2, 1);
        load(KIND_BIAS, 1, 16'h0010);
        load(KIND_WEIGHT, 4, 16'h0000);
        compute(1, 0, 0);
        load(KIND_BIAS, 1, 16'hF000);
        compute(1, 1, 1);
        load(KIND_BIAS, 1, 16'h0C00);
        compute(1, 0, 1);

        // Degenerate and extreme settings
        set_all(0, 0, 0, 3, 3, 0, 0, 0);            // no taps, zero stride, one group
        run_phase(20);
        set_all(3, 1, 1, 0, 0, 2, 1, 1);            // empty map, padding only
        run_phase(15);
        set_all(2, 4, 3, 5, 7, 3, 0, 1);
        run_phase(30);
        set_all(7, 4, 3, 128, 128, 256, 256, 1);    // full 128x128 map, 256 channels per group
        run_phase(5);
        set_all(7, 7, 3, 255, 255, 511, 511, 0);    // register fields at their top, SiLU off
        run_phase(5);
        set_all(7, 1, 0, 9, 9, 1, 1, 1);
        run_phase(20);

        // Random settings, kept small so most points are cheap
        while (sent_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                set_all($urandom_range(1, 7), $urandom_range(0, 7), $urandom_range(0, 3),
                        $urandom_range(1, 128), $urandom_range(1, 128),
                        $urandom_range(1, 2), $urandom_range(1, 256), $urandom_range(0, 1));
            else
                set_all($urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(0, 3),
                        $urandom_range(1, 12), $urandom_range(1, 12),
                        $urandom_range(1, 4), $urandom_range(1, 8), $urandom_range(0, 1));
            run_phase($urandom_range(60, 180));
        end

        drain();
        if (fail_count == 0)
            $display("grouped_conv2d_point_unit regression: pass");
        else
            $display("grouped_conv2d_point_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gcp_pkg.sv
rtl/gcp_ram.sv
rtl/gcp_mac.sv
rtl/gcp_act.sv
rtl/grouped_conv2d_point_unit.sv
tb/grouped_conv2d_point_checker.sv
tb/tb_grouped_conv2d_point_unit.sv
